### src/cma_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cma_pkg: shared types and constants
// Default sizes, the register reset value and the sequencer state type of
// the centered moving average filter.
// ----------------------------------------------------------------------------
package cma_pkg;

  // default sizes
  localparam int MAX_HALF_DEF    = 7;
  localparam int SAMPLE_BITS_DEF = 16;

  // half window register
  localparam int                HW_W       = 3;
  localparam logic [HW_W-1:0]   HALF_RESET = 3'd1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLAN,
    ST_WIN,
    ST_SUM,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

### src/cma_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cma_if: stream and register write channels
// Valid/ready channels for the sample input, the result output and the
// half window register write.
// ----------------------------------------------------------------------------
interface cma_in_if #(
  parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          end_of_signal;

  modport source (output valid, sample, end_of_signal, input ready);
  modport sink   (input valid, sample, end_of_signal, output ready);
endinterface

interface cma_out_if #(
  parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] average;
  logic                          last_output;

  modport source (output valid, average, last_output, input ready);
  modport sink   (input valid, average, last_output, output ready);
endinterface

interface cma_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [cma_pkg::HW_W-1:0]    half_window;

  modport source (output valid, half_window, input ready);
  modport sink   (input valid, half_window, output ready);
endinterface
`default_nettype wire

### src/centered_moving_average.sv
`default_nettype none
// ----------------------------------------------------------------------------
// centered_moving_average: centered moving average filter
// Mean of each sample's neighborhood of half_window samples on both sides,
// clipped at the ends of a signal, truncated toward zero.
// ----------------------------------------------------------------------------
// Usage:
//   samples: one Q8.8 sample per beat; end_of_signal marks a signal's last.
//   results: one mean per beat; last_output flags a signal's final result.
//   cfg:     writes half_window; write only while no beat is in flight.
// Results lag the input by half_window samples; the last sample of a signal
// flushes all pending positions, then the count and ring pointer clear.
// Steps: a sample beat is planned (PLAN), then each result runs WIN, SUM,
//   DIV and EMIT. SUM reads the samples of the window through the single
//   ring read port (one tap per cycle); DIV runs the one bit per cycle
//   divider on SUM_W = SAMPLE_BITS + clog2(2*MAX_HALF+1) bits. No new
//   sample beat is taken until the current beat's last result is emitted.
// A finished result sits in the output register, so the next sample beat is
// taken while the receiver stalls; a new result waits until that one leaves.
// Reset clears the count, pointer and output valid; half_window goes to 1.
// ----------------------------------------------------------------------------
module centered_moving_average #(
  parameter int MAX_HALF    = cma_pkg::MAX_HALF_DEF,
  parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  cma_in_if.sink     samples,
  cma_out_if.source  results,
  cma_cfg_if.sink    cfg
);

  localparam int RING_DEPTH = 2 * MAX_HALF + 1;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int SUM_W      = SAMPLE_BITS + $clog2(RING_DEPTH);

  // configuration and per-signal state
  logic [cma_pkg::HW_W-1:0]  half_window;
  logic [IDX_W-1:0]          h;
  logic [IDX_W-1:0]          wp;
  logic [CNT_W-1:0]          seen;
  logic [IDX_W-1:0]          seen_m1;

  // per-beat and per-result registers
  cma_pkg::state_t           state;
  cma_pkg::state_t           state_next;
  logic [IDX_W-1:0]          newest;
  logic                      eos;
  logic [IDX_W-1:0]          d;
  logic [IDX_W-1:0]          hi;
  logic [IDX_W-1:0]          hi_next;
  logic [IDX_W-1:0]          k;
  logic [CNT_W-1:0]          cnt;
  logic                      pend;
  logic signed [SUM_W-1:0]   acc;
  logic                      neg;

  // ring memory
  logic [SAMPLE_BITS-1:0]    ring [RING_DEPTH];
  logic [SAMPLE_BITS-1:0]    rd_data;
  logic [IDX_W-1:0]          rd_addr;
  logic [IDX_W:0]            ring_wrap;

  // control
  logic                      in_fire;
  logic                      out_fire;
  logic                      issue;
  logic                      div_start;
  logic                      div_done;
  logic [SUM_W-1:0]          div_num;
  logic [SUM_W-1:0]          div_quo;
  logic [SUM_W-1:0]          res;
  logic                      load_out;
  logic                      final_res;
  logic [IDX_W:0]            reach;

  // output register
  logic                      out_valid;
  logic [SAMPLE_BITS-1:0]    out_avg;
  logic                      out_last;

  // clamp the half window to the ring size
  always_comb begin
    if (int'(half_window) > MAX_HALF) begin
      h = IDX_W'(MAX_HALF);
    end else begin
      h = IDX_W'(half_window);
    end
  end

  assign seen_m1 = IDX_W'(seen - CNT_W'(1));

  // handshakes
  assign samples.ready = (state == cma_pkg::ST_IDLE);
  assign in_fire       = samples.valid && samples.ready;
  assign cfg.ready     = 1'b1;
  assign results.valid       = out_valid;
  assign results.average     = out_avg;
  assign results.last_output = out_last;
  assign out_fire      = out_valid && results.ready;

  // window reach d + h, clipped to the samples present (low end is tap 0)
  always_comb begin
    reach = {1'b0, d} + {1'b0, h};
    if (reach > {1'b0, seen_m1}) begin
      hi_next = seen_m1;
    end else begin
      hi_next = reach[IDX_W-1:0];
    end
  end

  // tap address: newest minus k, wrapped around the ring
  always_comb begin
    ring_wrap = {1'b0, newest} + (IDX_W+1)'(RING_DEPTH) - {1'b0, k};
    if (newest >= k) begin
      rd_addr = newest - k;
    end else begin
      rd_addr = ring_wrap[IDX_W-1:0];
    end
  end

  assign issue     = (state == cma_pkg::ST_SUM) && ({1'b0, k} <= {1'b0, hi});
  assign div_start = (state == cma_pkg::ST_SUM) && !issue && !pend;
  assign div_num   = acc[SUM_W-1] ? SUM_W'(-acc) : SUM_W'(acc);
  assign res       = neg ? SUM_W'(-div_quo) : div_quo;
  assign load_out  = (state == cma_pkg::ST_EMIT) && (!out_valid || results.ready);
  assign final_res = !eos || (d == '0);

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      cma_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_next = cma_pkg::ST_PLAN;
        end
      end
      cma_pkg::ST_PLAN: begin
        if (eos || (seen > CNT_W'(h))) begin
          state_next = cma_pkg::ST_WIN;
        end else begin
          state_next = cma_pkg::ST_IDLE;
        end
      end
      cma_pkg::ST_WIN: begin
        state_next = cma_pkg::ST_SUM;
      end
      cma_pkg::ST_SUM: begin
        if (div_start) begin
          state_next = cma_pkg::ST_DIV;
        end
      end
      cma_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = cma_pkg::ST_EMIT;
        end
      end
      cma_pkg::ST_EMIT: begin
        if (load_out) begin
          state_next = final_res ? cma_pkg::ST_IDLE : cma_pkg::ST_WIN;
        end
      end
      default: begin
        state_next = cma_pkg::ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cma_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      half_window <= cma_pkg::HALF_RESET;
    end else if (cfg.valid && cfg.ready) begin
      half_window <= cfg.half_window;
    end
  end

  // ring pointer and sample count: advance on a beat, clear after a flush
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      seen <= '0;
    end else if (in_fire) begin
      wp <= (wp == IDX_W'(RING_DEPTH - 1)) ? '0 : wp + IDX_W'(1);
      if (seen != CNT_W'(RING_DEPTH)) begin
        seen <= seen + CNT_W'(1);
      end
    end else if (load_out && final_res && eos) begin
      wp   <= '0;
      seen <= '0;
    end
  end

  // ring memory: write on the input beat, registered read of one tap
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ring[wp] <= samples.sample;
    end
    rd_data <= ring[rd_addr];
  end

  // read pipeline flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= issue;
    end
  end

  // beat, window and accumulator datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      newest <= wp;
      eos    <= samples.end_of_signal;
    end
    if (state == cma_pkg::ST_PLAN) begin
      // a flush starts at the oldest position not yet emitted
      if (eos && (seen_m1 < h)) begin
        d <= seen_m1;
      end else begin
        d <= h;
      end
    end
    if (state == cma_pkg::ST_WIN) begin
      hi  <= hi_next;
      cnt <= CNT_W'(hi_next) + CNT_W'(1);
      k   <= '0;
      acc <= '0;
    end
    if (issue) begin
      k <= k + IDX_W'(1);
    end
    if (pend) begin
      acc <= acc + SUM_W'(signed'(rd_data));
    end
    if (div_start) begin
      neg <= acc[SUM_W-1];
    end
    if (load_out && !final_res) begin
      d <= d - IDX_W'(1);
    end
  end

  cma_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (cnt),
    .done  (div_done),
    .quo   (div_quo)
  );

  // output register: hold until taken, refill when empty or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_avg  <= res[SAMPLE_BITS-1:0];
      out_last <= eos && (d == '0);
    end
  end

`ifndef SYNTHESIS
  a_wp_range: assert property (@(posedge clk) disable iff (rst)
    wp < IDX_W'(RING_DEPTH))
    else $error("ring pointer beyond ring depth");

  a_seen_range: assert property (@(posedge clk) disable iff (rst)
    seen <= CNT_W'(RING_DEPTH))
    else $error("sample count beyond ring depth");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (cnt != '0) && (cnt <= seen))
    else $error("divide started with a bad sample count");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == cma_pkg::ST_DIV)
    else $error("divider finished outside the divide state");
`endif

endmodule
`default_nettype wire

### src/cma_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cma_div: restoring unsigned divider
// Divides a NUM_W-bit magnitude by a DEN_W-bit count, one quotient bit per
// cycle. done pulses as the last quotient bit is registered; quo then holds.
// ----------------------------------------------------------------------------
module cma_div #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quo
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  // shift in the next dividend bit and try the subtract
  always_comb begin
    trial = {rem, quo[NUM_W-1]};
    ge    = trial >= {1'b0, den_r};
    diff  = trial - {1'b0, den_r};
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= busy && (steps == STEP_W'(1));
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(NUM_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // remainder and quotient datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_r <= den;
    end else if (busy) begin
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire
